FILE: rtl/core/midi_token_event_decoder_top_macros.svh
// Assertion macros for the token event decoder.
// Used by midi_token_event_decoder_top; expects clk and rst in scope.
`ifndef MIDI_TOKEN_EVENT_DECODER_TOP_MACROS_SVH
`define MIDI_TOKEN_EVENT_DECODER_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define MTED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MTED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mted_pkg.sv
// Shared types, constants and table functions of the token event decoder.
// No dependencies; used by every module of the block.
package mted_pkg;

  localparam int TOK_W      = 12;
  localparam int RAW_W      = 11;
  localparam int CNT_W      = 4;
  localparam int NUM_LANES  = 7;
  localparam int BPM_W      = 9;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 7;
  localparam int QUO_W      = DIV_STEPS * DIV_STAGES;
  localparam int TEMPO_W    = 26;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [QUO_W-1:0] TEMPO_DIVIDEND = QUO_W'(60000000);
  localparam logic [TOK_W-1:0] EVENT_ID_BASE  = TOK_W'(3);
  localparam logic             REG_VOCAB_VERSION = 1'b0;

  typedef enum logic [2:0] {
    K_NOTE, K_PATCH, K_CONTROL, K_TEMPO, K_TIMESIG, K_KEYSIG
  } kind_t;

  typedef enum logic [3:0] {
    P_T1, P_T2, P_DUR, P_TRK, P_CH, P_PIT, P_VEL, P_PAT,
    P_CTL, P_VAL, P_BPM, P_NN, P_DD, P_SF, P_MI
  } param_t;

  typedef struct packed {
    logic             hit;
    param_t           param;
    logic [RAW_W-1:0] raw;
  } lane_res_t;

  typedef struct packed {
    logic               ok;
    logic [2:0]         kind;
    logic [6:0]         track;
    logic [3:0]         channel;
    logic [RAW_W-1:0]   duration;
    logic signed [7:0]  key;
    logic [6:0]         level;
    logic [BPM_W-1:0]   bpm;
  } evt_t;

  function automatic logic [2:0] num_kinds(logic v);
    return v ? 3'd6 : 3'd4;
  endfunction

  function automatic logic [2:0] kind_len(logic v, logic [2:0] kind);
    logic [2:0] len;
    case (kind)
      K_NOTE:              len = 3'd7;
      K_PATCH:             len = 3'd5;
      K_CONTROL:           len = 3'd6;
      K_TEMPO:             len = 3'd4;
      K_TIMESIG, K_KEYSIG: len = v ? 3'd5 : 3'd0;
      default:             len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic param_t kind_param(logic v, logic [2:0] kind, logic [2:0] slot);
    param_t p;
    p = P_T1;
    case (slot)
      3'd0: p = P_T1;
      3'd1: p = P_T2;
      3'd2: p = P_TRK;
      3'd3: begin
        case (kind)
          K_NOTE:             p = v ? P_CH : P_DUR;
          K_PATCH, K_CONTROL: p = P_CH;
          K_TEMPO:            p = P_BPM;
          K_TIMESIG:          p = P_NN;
          K_KEYSIG:           p = P_SF;
          default:            p = P_T1;
        endcase
      end
      3'd4: begin
        case (kind)
          K_NOTE:    p = v ? P_PIT : P_CH;
          K_PATCH:   p = P_PAT;
          K_CONTROL: p = P_CTL;
          K_TIMESIG: p = P_DD;
          K_KEYSIG:  p = P_MI;
          default:   p = P_T1;
        endcase
      end
      3'd5: begin
        case (kind)
          K_NOTE:    p = v ? P_VEL : P_PIT;
          K_CONTROL: p = P_VAL;
          default:   p = P_T1;
        endcase
      end
      3'd6: begin
        case (kind)
          K_NOTE:  p = v ? P_DUR : P_VEL;
          default: p = P_T1;
        endcase
      end
      default: p = P_T1;
    endcase
    return p;
  endfunction

  function automatic logic [TOK_W-1:0] param_base(logic v, param_t p);
    logic [TOK_W-1:0] ofs;
    case (p)
      P_T1:    ofs = 12'd0;
      P_T2:    ofs = 12'd128;
      P_DUR:   ofs = 12'd144;
      P_TRK:   ofs = 12'd2192;
      P_CH:    ofs = 12'd2320;
      P_PIT:   ofs = 12'd2336;
      P_VEL:   ofs = 12'd2464;
      P_PAT:   ofs = 12'd2592;
      P_CTL:   ofs = 12'd2720;
      P_VAL:   ofs = 12'd2848;
      P_BPM:   ofs = 12'd2976;
      P_NN:    ofs = 12'd3360;
      P_DD:    ofs = 12'd3376;
      P_SF:    ofs = 12'd3380;
      P_MI:    ofs = 12'd3395;
      default: ofs = 12'd0;
    endcase
    return ofs + (EVENT_ID_BASE + TOK_W'(num_kinds(v)));
  endfunction

  function automatic logic [TOK_W-1:0] param_size(logic v, param_t p);
    logic [TOK_W-1:0] sz;
    case (p)
      P_T1, P_TRK, P_PIT, P_VEL, P_PAT, P_CTL, P_VAL: sz = 12'd128;
      P_T2, P_CH: sz = 12'd16;
      P_DUR:      sz = 12'd2048;
      P_BPM:      sz = v ? 12'd384 : 12'd256;
      P_NN:       sz = v ? 12'd16 : 12'd0;
      P_DD:       sz = v ? 12'd4 : 12'd0;
      P_SF:       sz = v ? 12'd15 : 12'd0;
      P_MI:       sz = v ? 12'd2 : 12'd0;
      default:    sz = 12'd0;
    endcase
    return sz;
  endfunction

  // Restoring division steps: returns {remainder, quotient}.
  function automatic logic [BPM_W+QUO_W-1:0] div_stage(
    logic [BPM_W-1:0] rem_i, logic [QUO_W-1:0] quo_i,
    logic [DIV_STEPS-1:0] bits, logic [BPM_W-1:0] d);
    logic [BPM_W:0]   r;
    logic [BPM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    rem = rem_i;
    quo = quo_i;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      r = {rem, bits[k]};
      if (r >= {1'b0, d}) begin
        r   = r - {1'b0, d};
        quo = {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo = {quo[QUO_W-2:0], 1'b0};
      end
      rem = r[BPM_W-1:0];
    end
    return {rem, quo};
  endfunction

endpackage

FILE: rtl/core/midi_token_event_decoder_top.sv
// Each result passes the decode stage register, then a 7-stage tempo divider
// whose last stage is the output register. Throughput: one group per cycle;
// the whole pipeline holds while a result waits on out_stall. Reset clears
// all valid bits and sets vocab_version to 1.
// Top level of the token event decoder: lanes, merge stage, tempo divider,
// APB register. Depends on mted_pkg, mted_lane, mted_merge, mted_tempo_div and the macros header.
module midi_token_event_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mted_pkg::ADDR_W-1:0]        paddr,
  input  logic [mted_pkg::DATA_W-1:0]        pwdata,
  output logic [mted_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mted_pkg::CNT_W-1:0]         token_count,
  input  logic [mted_pkg::TOK_W-1:0]         token_0,
  input  logic [mted_pkg::TOK_W-1:0]         token_1,
  input  logic [mted_pkg::TOK_W-1:0]         token_2,
  input  logic [mted_pkg::TOK_W-1:0]         token_3,
  input  logic [mted_pkg::TOK_W-1:0]         token_4,
  input  logic [mted_pkg::TOK_W-1:0]         token_5,
  input  logic [mted_pkg::TOK_W-1:0]         token_6,
  input  logic [mted_pkg::TOK_W-1:0]         token_7,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               ok,
  output logic [2:0]                         event_kind,
  output logic [6:0]                         track,
  output logic [3:0]                         channel,
  output logic [mted_pkg::RAW_W-1:0]         duration,
  output logic signed [7:0]                  key,
  output logic [6:0]                         level,
  output logic [mted_pkg::TEMPO_W-1:0]       tempo_us
);

  logic                                            vocab_version;
  logic                                            en;
  logic [mted_pkg::TOK_W-1:0]                      head_diff;
  logic [2:0]                                      kind;
  logic                                            head_ok;
  logic [mted_pkg::TOK_W-1:0]                      tok [mted_pkg::NUM_LANES];
  mted_pkg::lane_res_t [mted_pkg::NUM_LANES-1:0]   lanes;
  mted_pkg::evt_t                                  merged;
  logic                                            s1_valid;
  mted_pkg::evt_t                                  s1_evt;
  mted_pkg::evt_t                                  res_evt;
  logic [mted_pkg::TEMPO_W-1:0]                    res_quo;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mted_pkg::REG_VOCAB_VERSION) ?
                  {{(mted_pkg::DATA_W-1){1'b0}}, vocab_version} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_version <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mted_pkg::REG_VOCAB_VERSION) begin
      vocab_version <= pwdata[0];
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign head_diff = token_0 - mted_pkg::EVENT_ID_BASE;
  assign kind      = head_diff[2:0];
  assign head_ok   = (token_0 >= mted_pkg::EVENT_ID_BASE) &&
                     (head_diff < mted_pkg::TOK_W'(mted_pkg::num_kinds(vocab_version)));

  assign tok[0] = token_1;
  assign tok[1] = token_2;
  assign tok[2] = token_3;
  assign tok[3] = token_4;
  assign tok[4] = token_5;
  assign tok[5] = token_6;
  assign tok[6] = token_7;

  for (genvar l = 0; l < mted_pkg::NUM_LANES; l++) begin : g_lane
    mted_lane u_lane (
      .version (vocab_version),
      .kind    (kind),
      .slot    (3'(l)),
      .token   (tok[l]),
      .res     (lanes[l])
    );
  end

  mted_merge u_merge (
    .version     (vocab_version),
    .head_ok     (head_ok),
    .kind        (kind),
    .token_count (token_count),
    .lanes       (lanes),
    .evt         (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_evt <= merged;
    end
  end

  mted_tempo_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .in_evt    (s1_evt),
    .out_valid (out_valid),
    .out_evt   (res_evt),
    .out_quo   (res_quo)
  );

  assign ok         = res_evt.ok;
  assign event_kind = res_evt.kind;
  assign track      = res_evt.track;
  assign channel    = res_evt.channel;
  assign duration   = res_evt.duration;
  assign key        = res_evt.key;
  assign level      = res_evt.level;
  assign tempo_us   = (res_evt.ok && res_evt.kind == mted_pkg::K_TEMPO) ? res_quo : '0;

`include "midi_token_event_decoder_top_macros.svh"

  `MTED_ASSERT_NOW(a_fail_zero, out_valid && !ok, event_kind == 3'd0 && track == 7'd0 && channel == 4'd0 && duration == '0 && key == 8'sd0 && level == 7'd0 && tempo_us == '0, "failed event carries nonzero fields")
  `MTED_ASSERT_NOW(a_tempo_range, out_valid && ok && event_kind == mted_pkg::K_TEMPO, tempo_us >= 26'd156250 && tempo_us <= 26'd60000000, "tempo quotient out of range")
  `MTED_ASSERT_NOW(a_keysig_range, out_valid && ok && event_kind == mted_pkg::K_KEYSIG, key >= -8'sd7 && key <= 8'sd7, "key signature out of range")
  `MTED_ASSERT_NEXT(a_s1_load, in_valid && !in_stall, s1_valid, "transfer did not reach decode stage")

endmodule

FILE: rtl/core/mted_lane.sv
// One parameter lane: picks the parameter of its slot, subtracts the base
// and range-checks the token. Depends on mted_pkg.
module mted_lane (
  input  logic                         version,
  input  logic [2:0]                   kind,
  input  logic [2:0]                   slot,
  input  logic [mted_pkg::TOK_W-1:0]   token,
  output mted_pkg::lane_res_t          res
);

  mted_pkg::param_t             p;
  logic [mted_pkg::TOK_W-1:0]   base;
  logic [mted_pkg::TOK_W-1:0]   size;
  logic [mted_pkg::TOK_W-1:0]   diff;

  assign p    = mted_pkg::kind_param(version, kind, slot);
  assign base = mted_pkg::param_base(version, p);
  assign size = mted_pkg::param_size(version, p);
  assign diff = token - base;

  assign res.hit   = (token >= base) && (diff < size);
  assign res.param = p;
  assign res.raw   = diff[mted_pkg::RAW_W-1:0];

endmodule

FILE: rtl/core/mted_merge.sv
// Merge stage: combines the lane results into one event by parameter.
// Depends on mted_pkg.
module mted_merge (
  input  logic                                              version,
  input  logic                                              head_ok,
  input  logic [2:0]                                        kind,
  input  logic [mted_pkg::CNT_W-1:0]                        token_count,
  input  mted_pkg::lane_res_t [mted_pkg::NUM_LANES-1:0]     lanes,
  output mted_pkg::evt_t                                    evt
);

  always_comb begin
    logic [2:0]                  len;
    logic                        all_hit;
    logic                        ok;
    mted_pkg::evt_t              e;
    logic [mted_pkg::RAW_W-1:0]  raw;
    len     = mted_pkg::kind_len(version, kind);
    all_hit = 1'b1;
    e       = '0;
    for (int i = 0; i < mted_pkg::NUM_LANES; i++) begin
      raw = lanes[i].raw;
      if (3'(i) < len) begin
        if (!lanes[i].hit) all_hit = 1'b0;
        case (lanes[i].param)
          mted_pkg::P_DUR: e.duration = raw;
          mted_pkg::P_TRK: e.track    = raw[6:0];
          mted_pkg::P_CH:  e.channel  = raw[3:0];
          mted_pkg::P_PIT, mted_pkg::P_PAT, mted_pkg::P_CTL: e.key = {1'b0, raw[6:0]};
          mted_pkg::P_VEL, mted_pkg::P_VAL: e.level = raw[6:0];
          mted_pkg::P_MI:  e.level    = {6'd0, raw[0]};
          mted_pkg::P_BPM: e.bpm      = raw[mted_pkg::BPM_W-1:0];
          mted_pkg::P_NN:  e.key      = {4'd0, raw[3:0]} + 8'd1;
          mted_pkg::P_DD:  e.level    = {5'd0, raw[1:0]} + 7'd1;
          mted_pkg::P_SF:  e.key      = {4'd0, raw[3:0]} - 8'd7;
          default: ;
        endcase
      end
    end
    ok = head_ok && (token_count > {1'b0, len}) && all_hit;
    e.ok   = ok;
    e.kind = kind;
    evt = ok ? e : '0;
  end

endmodule

FILE: rtl/core/mted_tempo_div.sv
// Pipelined divider for the tempo: 60000000 / bpm, four quotient bits per
// stage, carrying the event alongside. Depends on mted_pkg.
module mted_tempo_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  mted_pkg::evt_t                    in_evt,
  output logic                              out_valid,
  output mted_pkg::evt_t                    out_evt,
  output logic [mted_pkg::TEMPO_W-1:0]      out_quo
);

  localparam int NS = mted_pkg::DIV_STAGES;
  localparam int QW = mted_pkg::QUO_W;
  localparam int BW = mted_pkg::BPM_W;

  logic [NS-1:0]   valid;
  mted_pkg::evt_t  evt   [NS];
  logic [BW-1:0]   rem   [NS];
  logic [QW-1:0]   quo   [NS];

  logic [NS-1:0]   valid_next;
  mted_pkg::evt_t  evt_next [NS];
  logic [BW-1:0]   rem_next [NS];
  logic [QW-1:0]   quo_next [NS];

  logic [BW-1:0]   rem_in   [NS];
  logic [QW-1:0]   quo_in   [NS];
  logic [BW-1:0]   divisor  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign valid_next[s] = in_valid;
      assign evt_next[s]   = in_evt;
      assign rem_in[s]     = '0;
      assign quo_in[s]     = '0;
    end else begin : g_rest
      assign valid_next[s] = valid[s-1];
      assign evt_next[s]   = evt[s-1];
      assign rem_in[s]     = rem[s-1];
      assign quo_in[s]     = quo[s-1];
    end
    assign divisor[s] = (evt_next[s].bpm == '0) ? BW'(1) : evt_next[s].bpm;
    assign {rem_next[s], quo_next[s]} = mted_pkg::div_stage(
      rem_in[s], quo_in[s],
      mted_pkg::TEMPO_DIVIDEND[QW-1-s*mted_pkg::DIV_STEPS -: mted_pkg::DIV_STEPS],
      divisor[s]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        evt[s] <= evt_next[s];
        rem[s] <= rem_next[s];
        quo[s] <= quo_next[s];
      end
    end
  end

  assign out_valid = valid[NS-1];
  assign out_evt   = evt[NS-1];
  assign out_quo   = quo[NS-1][mted_pkg::TEMPO_W-1:0];

endmodule

FILE: tb/sv/midi_token_event_decoder_checker.sv
// Checker for the token event decoder: watches the group, event and register
// transfers, predicts each event and compares it field by field.
// Depends on mted_pkg for the event kind and parameter enums.
module midi_token_event_decoder_checker
  import mted_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [CNT_W-1:0]    token_count,
  input  logic [TOK_W-1:0]    token_0,
  input  logic [TOK_W-1:0]    token_1,
  input  logic [TOK_W-1:0]    token_2,
  input  logic [TOK_W-1:0]    token_3,
  input  logic [TOK_W-1:0]    token_4,
  input  logic [TOK_W-1:0]    token_5,
  input  logic [TOK_W-1:0]    token_6,
  input  logic [TOK_W-1:0]    token_7,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                ok,
  input  logic [2:0]          event_kind,
  input  logic [6:0]          track,
  input  logic [3:0]          channel,
  input  logic [RAW_W-1:0]    duration,
  input  logic signed [7:0]   key,
  input  logic [6:0]          level,
  input  logic [TEMPO_W-1:0]  tempo_us,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic               ok;
    logic [2:0]         kind;
    logic [6:0]         track;
    logic [3:0]         channel;
    logic [RAW_W-1:0]   duration;
    logic signed [7:0]  key;
    logic [6:0]         level;
    logic [TEMPO_W-1:0] tempo_us;
  } event_rec_t;

  event_rec_t pending_events[$];
  event_rec_t want;
  logic       vocab_v = 1'b1;
  int         fails = 0;

  function automatic int layout_size(logic v, param_t p);
    case (p)
      P_T1, P_TRK, P_PIT, P_VEL, P_PAT, P_CTL, P_VAL: return 128;
      P_T2, P_CH: return 16;
      P_DUR:      return 2048;
      P_BPM:      return v ? 384 : 256;
      P_NN:       return v ? 16 : 0;
      P_DD:       return v ? 4 : 0;
      P_SF:       return v ? 15 : 0;
      P_MI:       return v ? 2 : 0;
      default:    return 0;
    endcase
  endfunction

  function automatic int layout_base(logic v, param_t p);
    int b;
    b = 3 + (v ? 6 : 4);
    for (int q = 0; q < int'(p); q++) b += layout_size(v, param_t'(q));
    return b;
  endfunction

  function automatic int group_len(int kind);
    case (kind)
      K_NOTE:    return 7;
      K_CONTROL: return 6;
      K_TEMPO:   return 4;
      default:   return 5;
    endcase
  endfunction

  function automatic param_t field_order(logic v, int kind, int slot);
    logic [3:0][3:0] tail;
    case (kind)
      K_NOTE:    tail = v ? {P_CH, P_PIT, P_VEL, P_DUR} : {P_DUR, P_CH, P_PIT, P_VEL};
      K_PATCH:   tail = {P_CH, P_PAT, P_T1, P_T1};
      K_CONTROL: tail = {P_CH, P_CTL, P_VAL, P_T1};
      K_TEMPO:   tail = {P_BPM, P_T1, P_T1, P_T1};
      K_TIMESIG: tail = {P_NN, P_DD, P_T1, P_T1};
      default:   tail = {P_SF, P_MI, P_T1, P_T1};
    endcase
    case (slot)
      0:       return P_T1;
      1:       return P_T2;
      2:       return P_TRK;
      default: return param_t'(tail[6 - slot]);
    endcase
  endfunction

  function automatic event_rec_t decode_group(logic v, logic [CNT_W-1:0] cnt_in,
                                              logic [7:0][TOK_W-1:0] toks);
    event_rec_t r;
    int         cnt, nk, kind, len, base, tok, raw;
    param_t     p;
    r = '0;
    cnt = (cnt_in > 8) ? 8 : int'(cnt_in);
    nk = v ? 6 : 4;
    if (cnt < 1) return r;
    if (toks[0] < 3 || toks[0] >= 3 + nk) return r;
    kind = int'(toks[0]) - 3;
    len = group_len(kind);
    if (cnt < len + 1) return r;
    for (int i = 0; i < len; i++) begin
      p = field_order(v, kind, i);
      base = layout_base(v, p);
      tok = int'(toks[i + 1]);
      if (tok < base || tok >= base + layout_size(v, p)) return '0;
      raw = tok - base;
      case (p)
        P_DUR:               r.duration = RAW_W'(raw);
        P_TRK:               r.track = 7'(raw);
        P_CH:                r.channel = 4'(raw);
        P_PIT, P_PAT, P_CTL: r.key = 8'(raw);
        P_VEL, P_VAL, P_MI:  r.level = 7'(raw);
        P_BPM:               r.tempo_us = TEMPO_W'(60000000 / (raw == 0 ? 1 : raw));
        P_NN:                r.key = 8'(raw + 1);
        P_DD:                r.level = 7'(raw + 1);
        P_SF:                r.key = 8'(raw - 7);
        default:             ;
      endcase
    end
    r.ok = 1'b1;
    r.kind = 3'(kind);
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      fails++;
      if (fails <= 10) begin
        $display("event mismatch on %s: expected %0d, got %0d", name, exp_val, got_val);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vocab_v = 1'b1;
      pending_events.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          fails++;
          if (fails <= 10) $display("event transfer with no group outstanding");
        end else begin
          want = pending_events.pop_front();
          compare_field("ok", want.ok, ok);
          compare_field("event_kind", want.kind, event_kind);
          compare_field("track", want.track, track);
          compare_field("channel", want.channel, channel);
          compare_field("duration", want.duration, duration);
          compare_field("key", $signed(want.key), $signed(key));
          compare_field("level", want.level, level);
          compare_field("tempo_us", want.tempo_us, tempo_us);
        end
      end
      if (in_valid && !in_stall) begin
        pending_events = {pending_events, decode_group(vocab_v, token_count,
          {token_7, token_6, token_5, token_4, token_3, token_2, token_1, token_0})};
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_VOCAB_VERSION) begin
        vocab_v = pwdata[0];
      end
    end
    pending <= pending_events.size();
    fail_count <= fails;
  end

endmodule

FILE: tb/sv/midi_token_event_decoder_top_test.sv
// Testbench top for the token event decoder: clock, reset, register writes,
// directed and random token groups with random gaps and output stalls.
// Depends on mted_pkg, midi_token_event_decoder_top and the checker module.
module midi_token_event_decoder_top_test;
  import mted_pkg::*;

  localparam logic [ADDR_W-1:0] VOCAB_ADDR = ADDR_W'(4 * REG_VOCAB_VERSION);

  logic                clk = 1'b0;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid, in_stall;
  logic [CNT_W-1:0]    token_count;
  logic [TOK_W-1:0]    token_0, token_1, token_2, token_3;
  logic [TOK_W-1:0]    token_4, token_5, token_6, token_7;
  logic                out_valid, out_stall;
  logic                ok;
  logic [2:0]          event_kind;
  logic [6:0]          track;
  logic [3:0]          channel;
  logic [RAW_W-1:0]    duration;
  logic signed [7:0]   key;
  logic [6:0]          level;
  logic [TEMPO_W-1:0]  tempo_us;
  int                  fail_count, pending;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  midi_token_event_decoder_top u_top (.*);

  midi_token_event_decoder_checker u_checker (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #(12 * 200000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_group(logic [CNT_W-1:0] cnt, logic [7:0][TOK_W-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    token_count <= cnt;
    token_0 <= t[0];
    token_1 <= t[1];
    token_2 <= t[2];
    token_3 <= t[3];
    token_4 <= t[4];
    token_5 <= t[5];
    token_6 <= t[6];
    token_7 <= t[7];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_vocab(logic val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VOCAB_ADDR;
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // pick: 0 all parameters at their lowest, 1 at their highest, else mixed
  function automatic logic [7:0][TOK_W-1:0] well_formed(logic v, int kind, int pick);
    logic [7:0][TOK_W-1:0] t;
    param_t                p;
    int                    sz, raw, r;
    for (int s = 0; s < 8; s++) t[s] = TOK_W'($urandom_range(4095));
    t[0] = TOK_W'(3 + kind);
    for (int s = 0; s < int'(kind_len(v, 3'(kind))); s++) begin
      p = kind_param(v, 3'(kind), 3'(s));
      sz = int'(param_size(v, p));
      r = $urandom_range(7);
      if (pick == 0 || (pick > 1 && r == 0)) raw = 0;
      else if (pick == 1 || r == 1) raw = sz - 1;
      else raw = $urandom_range(sz - 1);
      t[s + 1] = param_base(v, p) + TOK_W'(raw);
    end
    return t;
  endfunction

  task automatic send_random(logic v);
    logic [7:0][TOK_W-1:0] t;
    logic [CNT_W-1:0]      cnt;
    logic [TOK_W-1:0]      base;
    param_t                p;
    int                    nk, kind, len, roll, s;
    nk = v ? 6 : 4;
    kind = $urandom_range(nk - 1);
    len = int'(kind_len(v, 3'(kind)));
    t = well_formed(v, kind, 2);
    cnt = CNT_W'($urandom_range(15, len + 1));
    roll = $urandom_range(99);
    if (roll < 6) begin
      if ($urandom_range(1)) t[0] = TOK_W'($urandom_range(2));
      else t[0] = TOK_W'($urandom_range(4095, 3 + nk));
    end else if (roll < 16) begin
      s = $urandom_range(len, 1);
      p = kind_param(v, 3'(kind), 3'(s - 1));
      base = param_base(v, p);
      case ($urandom_range(2))
        0:       t[s] = base - 1'b1;
        1:       t[s] = base + param_size(v, p);
        default: t[s] = TOK_W'($urandom_range(4095));
      endcase
    end else if (roll < 22) begin
      cnt = CNT_W'($urandom_range(len));
    end else if (roll < 30) begin
      cnt = CNT_W'($urandom_range(15));
    end
    send_group(cnt, t);
  endtask

  initial begin
    logic [7:0][TOK_W-1:0] t;
    logic                  cur_v;
    int                    mode;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    token_count <= '0;
    token_0 <= '0;
    token_1 <= '0;
    token_2 <= '0;
    token_3 <= '0;
    token_4 <= '0;
    token_5 <= '0;
    token_6 <= '0;
    token_7 <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_group(4'd8, well_formed(1'b1, K_NOTE, 0));
    send_group(4'd15, well_formed(1'b1, K_NOTE, 1));
    send_group(4'd6, well_formed(1'b1, K_PATCH, 1));
    send_group(4'd7, well_formed(1'b1, K_CONTROL, 0));
    t = well_formed(1'b1, K_TEMPO, 0);
    send_group(4'd5, t);
    t[4] = t[4] + 1'b1;
    send_group(4'd5, t);
    send_group(4'd12, well_formed(1'b1, K_TEMPO, 1));
    send_group(4'd6, well_formed(1'b1, K_TIMESIG, 1));
    send_group(4'd6, well_formed(1'b1, K_KEYSIG, 0));
    send_group(4'd9, well_formed(1'b1, K_KEYSIG, 1));
    send_group(4'd0, well_formed(1'b1, K_PATCH, 0));
    send_group(4'd7, well_formed(1'b1, K_NOTE, 1));
    t = well_formed(1'b1, K_PATCH, 0);
    t[0] = 12'd0;
    send_group(4'd8, t);
    t[0] = 12'd2;
    send_group(4'd8, t);
    t[0] = 12'd9;
    send_group(4'd8, t);
    t[0] = 12'd4095;
    send_group(4'd8, t);
    t = well_formed(1'b1, K_PATCH, 0);
    t[5] = t[5] - 1'b1;
    send_group(4'd6, t);
    t = well_formed(1'b1, K_PATCH, 1);
    t[4] = t[4] + 1'b1;
    send_group(4'd6, t);
    drain();

    write_vocab(1'b0);
    send_group(4'd8, well_formed(1'b0, K_NOTE, 0));
    send_group(4'd8, well_formed(1'b0, K_NOTE, 1));
    send_group(4'd5, well_formed(1'b0, K_TEMPO, 1));
    t = well_formed(1'b0, K_TEMPO, 1);
    t[4] = t[4] + 1'b1;
    send_group(4'd5, t);
    t = well_formed(1'b1, K_TIMESIG, 0);
    t[0] = 12'd7;
    send_group(4'd6, t);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cur_v = ph[0];
      mode = ph / 2;
      idle_pct = (mode == 1) ? 55 : (mode == 3) ? 14 : 0;
      stall_pct = (mode == 2) ? 55 : (mode == 3) ? 14 : 0;
      write_vocab(cur_v);
      for (int n = 0; n < 112; n++) send_random(cur_v);
      drain();
    end

    stall_pct = 0;
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
